// ===== rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Operation and status codes shared by the pending signal controller.
// ----------------------------------------------------------------------------
package psc_pkg;

    typedef enum logic [1:0] {
        MODE_SEND    = 2'd0,
        MODE_TAKE    = 2'd1,
        MODE_BLOCK   = 2'd2,
        MODE_UNBLOCK = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_BLOCKED   = 3'd2,
        ST_PROTECTED = 3'd3,
        ST_FULL      = 3'd4,
        ST_NONE      = 3'd5
    } status_t;

    localparam int SIG_NUM_W  = 7;
    localparam int SIG_OUT_W  = 6;
    localparam int COUNT_W    = 8;

endpackage

// ===== rtl/pending_signal_controller.sv =====
// ----------------------------------------------------------------------------
// pending_signal_controller
// Pending and blocked state of one task's signals: send, take, block and
// unblock requests; standard signals as pending bits, realtime signals in a
// bounded queue held in a RAM.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  mode, signal_number
//   out      output     out_valid / out_stall status, delivered_signal,
//                                            delivered_valid, pending_total
//
// each request has an accept step (queue head read issued to the RAM)
// and an execute step, which uses the registered RAM read data
// one result per request, held in an output register; a stalled result
// holds the execute step, and a new request is taken while it waits
// reset clears masks, pointers, fill and counter; the queue RAM is not
// cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module pending_signal_controller #(
    parameter int NUM_SIGNALS  = 64,
    parameter int NUM_STANDARD = 32,
    parameter int QUEUE_DEPTH  = 16,
    parameter int KILL_SIGNAL  = 9,
    parameter int STOP_SIGNAL  = 19
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [6:0] signal_number,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [5:0] delivered_signal,
    output logic       delivered_valid,
    output logic [7:0] pending_total
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CW     = psc_pkg::COUNT_W;
    localparam int SW     = psc_pkg::SIG_NUM_W;
    localparam int OW     = psc_pkg::SIG_OUT_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                state_reg;
    psc_pkg::mode_t        mode_reg;
    logic [SW-1:0]         sig_reg;
    logic [NUM_STANDARD-1:0] std_reg, std_next;
    logic [NUM_SIGNALS-1:0]  blk_reg, blk_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    logic                  out_valid_reg;
    psc_pkg::status_t      status_reg, status_next;
    logic [OW-1:0]         dsig_reg, dsig_next;
    logic                  dvalid_reg, dvalid_next;

    logic                  accept;
    logic                  finish;
    logic                  push;
    logic [OW-1:0]         q_rd_data;

    logic [NUM_STANDARD-1:0] std_hot;
    logic [NUM_SIGNALS-1:0]  sig_hot;
    logic [NUM_STANDARD-1:0] std_low;
    logic [OW-1:0]         std_idx;
    logic                  std_found;
    logic                  sig_ok;
    logic                  sig_std;
    logic                  sig_blocked;
    logic                  sig_protected;
    logic                  q_full;
    logic [CW-1:0]         cnt_inc;
    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      tail_inc;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign finish   = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    psc_ram #(
        .WIDTH (OW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (finish && push),
        .wr_addr (tail_reg),
        .wr_data (sig_reg[OW-1:0]),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (q_rd_data)
    );

    // signal decode and lowest pending standard signal
    always_comb
    begin
        std_found = 1'b0;
        std_idx   = '0;
        for (int i = 0; i < NUM_STANDARD; i++)
        begin
            std_hot[i] = (sig_reg == SW'(i));
        end
        for (int i = 0; i < NUM_SIGNALS; i++)
        begin
            sig_hot[i] = (sig_reg == SW'(i));
        end
        for (int i = NUM_STANDARD - 1; i >= 0; i--)
        begin
            if (std_reg[i])
            begin
                std_found = 1'b1;
                std_idx   = OW'(i);
            end
        end
    end

    assign std_low       = std_reg & (~std_reg + NUM_STANDARD'(1));
    assign sig_ok        = (sig_reg < SW'(NUM_SIGNALS));
    assign sig_std       = (sig_reg < SW'(NUM_STANDARD));
    assign sig_blocked   = |(blk_reg & sig_hot);
    assign sig_protected = (sig_reg == SW'(KILL_SIGNAL)) || (sig_reg == SW'(STOP_SIGNAL));
    assign q_full        = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign cnt_inc       = (cnt_reg == {CW{1'b1}}) ? cnt_reg : cnt_reg + CW'(1);
    assign head_inc      = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc      = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);

    // request execution
    always_comb
    begin
        std_next    = std_reg;
        blk_next    = blk_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        status_next = psc_pkg::ST_OK;
        dsig_next   = '0;
        dvalid_next = 1'b0;
        push        = 1'b0;
        unique case (mode_reg)
            psc_pkg::MODE_SEND:
            begin
                if (!sig_ok)
                begin
                    status_next = psc_pkg::ST_INVALID;
                end
                else if (sig_blocked)
                begin
                    status_next = psc_pkg::ST_BLOCKED;
                end
                else if (sig_std)
                begin
                    std_next = std_reg | std_hot;
                    cnt_next = cnt_inc;
                end
                else if (q_full)
                begin
                    status_next = psc_pkg::ST_FULL;
                end
                else
                begin
                    push      = 1'b1;
                    tail_next = tail_inc;
                    fill_next = fill_reg + FILL_W'(1);
                    cnt_next  = cnt_inc;
                end
            end
            psc_pkg::MODE_TAKE:
            begin
                status_next = psc_pkg::ST_NONE;
                if (cnt_reg != '0)
                begin
                    if (std_found)
                    begin
                        std_next    = std_reg & ~std_low;
                        dsig_next   = std_idx;
                        dvalid_next = 1'b1;
                        cnt_next    = cnt_reg - CW'(1);
                        status_next = psc_pkg::ST_OK;
                    end
                    else if (fill_reg != '0)
                    begin
                        dsig_next   = q_rd_data;
                        dvalid_next = 1'b1;
                        head_next   = head_inc;
                        fill_next   = fill_reg - FILL_W'(1);
                        cnt_next    = cnt_reg - CW'(1);
                        status_next = psc_pkg::ST_OK;
                    end
                end
            end
            psc_pkg::MODE_BLOCK:
            begin
                if (!sig_ok)
                begin
                    status_next = psc_pkg::ST_INVALID;
                end
                else if (sig_protected)
                begin
                    status_next = psc_pkg::ST_PROTECTED;
                end
                else
                begin
                    blk_next = blk_reg | sig_hot;
                end
            end
            psc_pkg::MODE_UNBLOCK:
            begin
                if (!sig_ok)
                begin
                    status_next = psc_pkg::ST_INVALID;
                end
                else
                begin
                    blk_next = blk_reg & ~sig_hot;
                end
            end
            default:
            begin
                status_next = psc_pkg::ST_OK;
            end
        endcase
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= psc_pkg::mode_t'(mode);
            sig_reg  <= signal_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            std_reg       <= '0;
            blk_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= psc_pkg::ST_OK;
            dsig_reg      <= '0;
            dvalid_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !finish)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (finish)
                    begin
                        state_reg     <= S_IDLE;
                        std_reg       <= std_next;
                        blk_reg       <= blk_next;
                        head_reg      <= head_next;
                        tail_reg      <= tail_next;
                        fill_reg      <= fill_next;
                        cnt_reg       <= cnt_next;
                        out_valid_reg <= 1'b1;
                        status_reg    <= status_next;
                        dsig_reg      <= dsig_next;
                        dvalid_reg    <= dvalid_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign delivered_signal = dsig_reg;
    assign delivered_valid  = dvalid_reg;
    assign pending_total    = cnt_reg;

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_ptr_fill : assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != tail_reg) |-> (fill_reg != '0))
        else $error("queue pointers apart with zero fill");

    a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request taken while another executes");

    a_delivered_ok : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && delivered_valid) |-> (status_reg == psc_pkg::ST_OK))
        else $error("delivered signal with failing status");

    a_take_no_set : assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (mode_reg == psc_pkg::MODE_TAKE)) |=> ((std_reg & ~$past(std_reg)) == '0))
        else $error("take raised a pending bit");

endmodule

// ===== rtl/psc_ram.sv =====
// ----------------------------------------------------------------------------
// psc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module psc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== verif/pending_signal_controller_tb.sv =====
// ----------------------------------------------------------------------------
// pending_signal_controller_tb
// Self-checking bench for the pending signal controller. A clocked driver
// feeds send, take, block and unblock requests from a prepared list, and a
// clocked monitor compares every result with the answer that a local
// predictor of the signal state worked out when the request was accepted.
// Both sides idle and stall at random; a directed opening covers the corner
// cases, a randomized body of request sequences follows, then a saturation run.
// ----------------------------------------------------------------------------
module pending_signal_controller_tb;

    localparam int NUM_SIGNALS  = 64;
    localparam int NUM_STANDARD = 32;
    localparam int QUEUE_DEPTH  = 16;
    localparam int KILL_SIGNAL  = 9;
    localparam int STOP_SIGNAL  = 19;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        psc_pkg::mode_t op;
        logic [6:0]     sig;
    } signal_req_t;

    typedef struct packed {
        psc_pkg::status_t st;
        logic [5:0]       dsig;
        logic             dvalid;
        logic [7:0]       total;
    } answer_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] mode = psc_pkg::MODE_SEND;
    logic [6:0] signal_number = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] status;
    logic [5:0] delivered_signal;
    logic       delivered_valid;
    logic [7:0] pending_total;

    // predicted signal state
    logic [NUM_STANDARD-1:0] std_pending = '0;
    logic [NUM_SIGNALS-1:0]  blocked_bits = '0;
    logic [5:0]              rt_fifo[$];
    logic [7:0]              pending_count = '0;

    signal_req_t request_list[$];
    answer_t     expected_answers[$];
    signal_req_t next_req;
    int          request_total = 0;
    int          accepted_count = 0;
    int          error_count = 0;
    int          feed_gap = 0;
    int          feed_calm = 0;
    int          stall_left = 0;
    int          stall_calm = 0;

    pending_signal_controller #(
        .NUM_SIGNALS  (NUM_SIGNALS),
        .NUM_STANDARD (NUM_STANDARD),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .KILL_SIGNAL  (KILL_SIGNAL),
        .STOP_SIGNAL  (STOP_SIGNAL)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .signal_number    (signal_number),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .delivered_signal (delivered_signal),
        .delivered_valid  (delivered_valid),
        .pending_total    (pending_total)
    );

    function automatic answer_t predict_answer(psc_pkg::mode_t op, logic [6:0] sig);
        answer_t ans;
        logic    in_range;
        ans = '{st: psc_pkg::ST_OK, dsig: '0, dvalid: 1'b0, total: '0};
        in_range = (sig < NUM_SIGNALS);
        case (op)
            psc_pkg::MODE_SEND:
            begin
                if (!in_range)
                    ans.st = psc_pkg::ST_INVALID;
                else if (blocked_bits[sig])
                    ans.st = psc_pkg::ST_BLOCKED;
                else if (sig < NUM_STANDARD)
                begin
                    std_pending[sig] = 1'b1;
                    if (pending_count != 8'hff)
                        pending_count++;
                end
                else if (rt_fifo.size() >= QUEUE_DEPTH)
                    ans.st = psc_pkg::ST_FULL;
                else
                begin
                    rt_fifo.push_back(sig[5:0]);
                    if (pending_count != 8'hff)
                        pending_count++;
                end
            end
            psc_pkg::MODE_TAKE:
            begin
                ans.st = psc_pkg::ST_NONE;
                if (pending_count != 0)
                begin
                    for (int i = 0; i < NUM_STANDARD; i++)
                    begin
                        if (!ans.dvalid && std_pending[i])
                        begin
                            std_pending[i] = 1'b0;
                            ans.dsig = 6'(i);
                            ans.dvalid = 1'b1;
                        end
                    end
                    if (!ans.dvalid && rt_fifo.size() != 0)
                    begin
                        ans.dsig = rt_fifo.pop_front();
                        ans.dvalid = 1'b1;
                    end
                    if (ans.dvalid)
                    begin
                        pending_count--;
                        ans.st = psc_pkg::ST_OK;
                    end
                end
            end
            psc_pkg::MODE_BLOCK:
            begin
                if (!in_range)
                    ans.st = psc_pkg::ST_INVALID;
                else if (sig == KILL_SIGNAL || sig == STOP_SIGNAL)
                    ans.st = psc_pkg::ST_PROTECTED;
                else
                    blocked_bits[sig] = 1'b1;
            end
            default:
            begin
                if (!in_range)
                    ans.st = psc_pkg::ST_INVALID;
                else
                    blocked_bits[sig] = 1'b0;
            end
        endcase
        ans.total = pending_count;
        return ans;
    endfunction

    // mostly short idles, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_req(input psc_pkg::mode_t op, input int sig);
        logic [6:0] s;
        s = sig[6:0];
        request_list.push_back('{op: op, sig: s});
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #10_000_000;
        $display("pending_signal_controller regression: fail");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= psc_pkg::MODE_SEND;
            signal_number <= '0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                expected_answers.push_back(
                    predict_answer(psc_pkg::mode_t'(mode), signal_number));
                accepted_count++;
            end
            if (feed_gap > 0)
            begin
                feed_gap--;
                in_valid <= 1'b0;
            end
            else if (request_list.size() != 0)
            begin
                next_req = request_list.pop_front();
                mode <= next_req.op;
                signal_number <= next_req.sig;
                in_valid <= 1'b1;
                if (feed_calm > 0)
                begin
                    feed_calm--;
                    feed_gap = 0;
                end
                else
                begin
                    feed_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        feed_calm = $urandom_range(20, 80);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, status);
                    error_count++;
                end
                else
                begin
                    answer_t want;
                    want = expected_answers.pop_front();
                    check_field("status", 8'(want.st), 8'(status));
                    check_field("delivered_signal", 8'(want.dsig), 8'(delivered_signal));
                    check_field("delivered_valid", 8'(want.dvalid), 8'(delivered_valid));
                    check_field("pending_total", want.total, pending_total);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (stall_calm > 0)
                    stall_calm--;
                else
                begin
                    stall_left = pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        stall_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    initial
    begin
        int n;
        int s;
        int held[$];

        // directed opening
        add_req(psc_pkg::MODE_TAKE, 0);
        add_req(psc_pkg::MODE_SEND, 64);
        add_req(psc_pkg::MODE_SEND, 127);
        add_req(psc_pkg::MODE_BLOCK, 100);
        add_req(psc_pkg::MODE_UNBLOCK, 127);
        add_req(psc_pkg::MODE_BLOCK, KILL_SIGNAL);
        add_req(psc_pkg::MODE_BLOCK, STOP_SIGNAL);
        add_req(psc_pkg::MODE_UNBLOCK, KILL_SIGNAL);
        add_req(psc_pkg::MODE_BLOCK, 63);
        add_req(psc_pkg::MODE_SEND, 63);
        add_req(psc_pkg::MODE_UNBLOCK, 63);
        add_req(psc_pkg::MODE_SEND, 0);
        add_req(psc_pkg::MODE_SEND, 0);
        add_req(psc_pkg::MODE_SEND, 31);
        add_req(psc_pkg::MODE_SEND, 32);
        add_req(psc_pkg::MODE_SEND, 63);
        add_req(psc_pkg::MODE_BLOCK, 0);
        add_req(psc_pkg::MODE_TAKE, 127);
        add_req(psc_pkg::MODE_UNBLOCK, 0);
        add_req(psc_pkg::MODE_TAKE, 85);
        add_req(psc_pkg::MODE_TAKE, 42);
        add_req(psc_pkg::MODE_TAKE, 0);
        add_req(psc_pkg::MODE_TAKE, 0);

        // randomized request sequences
        while (request_list.size() < 700)
        begin
            held.delete();
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n = $urandom_range(4, 16);
                    repeat (n)
                        add_req(psc_pkg::mode_t'($urandom_range(0, 3)),
                                $urandom_range(0, 127));
                end
                2, 3, 4:
                begin
                    n = $urandom_range(1, 12);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 1))
                            add_req(psc_pkg::MODE_SEND, $urandom_range(0, NUM_STANDARD - 1));
                        else
                            add_req(psc_pkg::MODE_SEND,
                                    $urandom_range(NUM_STANDARD, NUM_SIGNALS - 1));
                    end
                    repeat (n + $urandom_range(0, 3))
                        add_req(psc_pkg::MODE_TAKE, $urandom_range(0, 127));
                end
                5, 6:
                begin
                    n = $urandom_range(2, 8);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            s = $urandom_range(0, 1) ? KILL_SIGNAL : STOP_SIGNAL;
                        else
                            s = $urandom_range(0, NUM_SIGNALS - 1);
                        add_req(psc_pkg::MODE_BLOCK, s);
                        held.push_back(s);
                    end
                    repeat ($urandom_range(2, 10))
                    begin
                        if ($urandom_range(0, 1) && held.size() != 0)
                            add_req(psc_pkg::MODE_SEND,
                                    held[$urandom_range(0, held.size() - 1)]);
                        else
                            add_req(psc_pkg::MODE_SEND, $urandom_range(0, NUM_SIGNALS - 1));
                    end
                    foreach (held[i])
                        add_req(psc_pkg::MODE_UNBLOCK, held[i]);
                    repeat ($urandom_range(2, 10))
                        add_req(psc_pkg::MODE_TAKE, $urandom_range(0, 127));
                end
                7, 8:
                begin
                    n = $urandom_range(QUEUE_DEPTH - 2, QUEUE_DEPTH + 4);
                    repeat (n)
                        add_req(psc_pkg::MODE_SEND,
                                $urandom_range(NUM_STANDARD, NUM_SIGNALS - 1));
                    repeat (n + 2) add_req(psc_pkg::MODE_TAKE, $urandom_range(0, 127));
                end
                default:
                begin
                    n = $urandom_range(3, 10);
                    repeat (n)
                        add_req(psc_pkg::mode_t'($urandom_range(0, 3)),
                                $urandom_range(NUM_SIGNALS, 127));
                end
            endcase
        end

        // drive the counter into saturation
        for (int i = 0; i < NUM_SIGNALS; i++)
            add_req(psc_pkg::MODE_UNBLOCK, i);
        repeat (270) add_req(psc_pkg::MODE_SEND, $urandom_range(0, NUM_STANDARD - 1));
        repeat (40) add_req(psc_pkg::MODE_TAKE, $urandom_range(0, 127));
        repeat (4) add_req(psc_pkg::MODE_SEND, $urandom_range(NUM_STANDARD, NUM_SIGNALS - 1));

        request_total = request_list.size();

        wait (rst_n);
        while (accepted_count < request_total || expected_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("pending_signal_controller regression: pass");
        else
            $display("pending_signal_controller regression: fail");
        $finish;
    end

endmodule
